// ===== design/mbd_pkg.sv =====
// Shared constants, types and codes for the boxcar decimator.
package mbd_pkg;

  localparam int MAX_CHANNELS   = 16;
  localparam int MAX_DECIMATION = 4096;

  localparam int SAMPLE_W  = 32;
  localparam int SUM_W     = 44;
  localparam int CH_W      = 4;
  localparam int NCH_W     = 5;
  localparam int DEC_W     = 13;
  localparam int WCNT_W    = 12;
  localparam int CFG_IDX_W = 2;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  localparam int DIV_STEPS = SUM_W;
  localparam int STEP_W    = 6;

  typedef logic [CFG_IDX_W-1:0] cfg_index_t;

  localparam cfg_index_t CFG_ENABLE        = 2'd0;
  localparam cfg_index_t CFG_DECIMATION    = 2'd1;
  localparam cfg_index_t CFG_CHANNEL_COUNT = 2'd2;

  // One unit of work handed from the front end to the back end.
  typedef struct packed {
    logic                    pass;
    logic signed [SUM_W-1:0] value;
    logic [DEC_W-1:0]        dec;
    logic [CH_W-1:0]         channel;
    logic                    last;
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIVIDE,
    BK_HOLD
  } back_state_t;

endpackage

// ===== design/mbd_front.sv =====
// Front end: configuration registers, channel tracking and per-channel accumulation.
module mbd_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  logic                          q_full,
  input  logic signed [31:0]            sample,
  input  logic                          cfg_we,
  input  mbd_pkg::cfg_index_t           cfg_index,
  input  logic [mbd_pkg::DEC_W-1:0]     cfg_data,
  output logic                          job_push,
  output mbd_pkg::job_t                 job
);
  import mbd_pkg::*;

  logic                    enable;
  logic [DEC_W-1:0]        decimation;
  logic [NCH_W-1:0]        channel_count;
  logic [CH_W-1:0]         position;
  logic [WCNT_W-1:0]       window_count;
  logic signed [SUM_W-1:0] sums [MAX_CHANNELS];

  logic [NCH_W-1:0]        nch;
  logic [DEC_W-1:0]        dec_eff;
  logic [CH_W-1:0]         pos_eff;
  logic                    is_last;
  logic                    pass;
  logic signed [SUM_W-1:0] sum_add;
  logic [DEC_W-1:0]        wc_ext;
  logic [DEC_W-1:0]        wc_inc;
  logic                    window_end;
  logic                    wc_wrap;
  logic                    accept;
  logic                    cfg_hit;

  always_comb begin
    if (channel_count == '0) begin
      nch = NCH_W'(1);
    end else if (channel_count > NCH_W'(MAX_CHANNELS)) begin
      nch = NCH_W'(MAX_CHANNELS);
    end else begin
      nch = channel_count;
    end
    dec_eff    = (decimation > DEC_W'(MAX_DECIMATION)) ? DEC_W'(MAX_DECIMATION) : decimation;
    pos_eff    = ({1'b0, position} >= nch) ? '0 : position;
    is_last    = ({1'b0, pos_eff} == (nch - NCH_W'(1)));
    pass       = !enable || (dec_eff <= DEC_W'(1));
    sum_add    = sums[pos_eff] + SUM_W'(sample);
    wc_ext     = {1'b0, window_count};
    wc_inc     = wc_ext + DEC_W'(1);
    window_end = (wc_ext >= (dec_eff - DEC_W'(1)));
    wc_wrap    = (wc_inc >= dec_eff);
    accept     = push && !q_full;
    job_push   = accept && (pass || window_end);

    job.pass    = pass;
    job.value   = pass ? SUM_W'(sample) : sum_add;
    job.dec     = dec_eff;
    job.channel = pos_eff;
    job.last    = is_last;

    cfg_hit = cfg_we && ((cfg_index == CFG_ENABLE) || (cfg_index == CFG_DECIMATION) ||
                         (cfg_index == CFG_CHANNEL_COUNT));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enable        <= 1'b0;
      decimation    <= DEC_W'(1);
      channel_count <= NCH_W'(1);
      position      <= '0;
      window_count  <= '0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        sums[i] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ENABLE:        enable        <= cfg_data[0];
        CFG_DECIMATION:    decimation    <= cfg_data;
        CFG_CHANNEL_COUNT: channel_count <= cfg_data[NCH_W-1:0];
        default: ;
      endcase
      // Any known register write restarts every window.
      if (cfg_hit) begin
        window_count <= '0;
        for (int i = 0; i < MAX_CHANNELS; i++) begin
          sums[i] <= '0;
        end
      end
    end else if (accept) begin
      position <= is_last ? '0 : pos_eff + CH_W'(1);
      if (!pass) begin
        sums[pos_eff] <= window_end ? '0 : sum_add;
        if (is_last) begin
          window_count <= wc_wrap ? '0 : wc_inc[WCNT_W-1:0];
        end
      end
    end
  end

endmodule

// ===== design/mbd_queue.sv =====
// Short job queue between the front end and the back end.
module mbd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_push,
  input  mbd_pkg::job_t q_din,
  input  logic          q_pop,
  output logic          q_full,
  output logic          q_empty,
  output mbd_pkg::job_t q_head
);
  import mbd_pkg::*;

  job_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign q_full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign q_empty = (count == '0);
  assign q_head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (q_push) begin
      slots[wr_ptr] <= q_din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (q_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      unique case ({q_push, q_pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_ptr_track: assert property (@(posedge clk) disable iff (rst)
    (wr_ptr - rd_ptr) == count[QPTR_W-1:0])
    else $error("queue pointers disagree with count");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !q_push)
    else $error("push into full queue");

endmodule

// ===== design/mbd_back.sv =====
// Back end: bit-serial signed division of window sums and the result register.
module mbd_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  input  mbd_pkg::job_t       q_head,
  output logic                q_pop,
  input  logic                pop,
  output logic                empty,
  output logic signed [31:0]  average,
  output logic [3:0]          channel,
  output logic                last_channel
);
  import mbd_pkg::*;

  back_state_t        state;
  back_state_t        state_next;
  logic               out_valid;
  logic [DEC_W-1:0]   rem;
  logic [SUM_W-1:0]   work;
  logic [DEC_W-1:0]   divisor;
  logic               neg;
  logic [STEP_W-1:0]  step;
  logic [CH_W-1:0]    job_ch;
  logic               job_last;

  logic               out_free;
  logic               load_pass;
  logic               load_div;
  logic [DEC_W:0]     trial;
  logic               ge;
  logic [DEC_W:0]     diff;

  always_comb begin
    out_free   = !out_valid || pop;
    q_pop      = 1'b0;
    load_pass  = 1'b0;
    load_div   = 1'b0;
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (!q_empty && out_free) begin
          q_pop = 1'b1;
          if (q_head.pass) begin
            load_pass = 1'b1;
          end else begin
            state_next = BK_DIVIDE;
          end
        end
      end
      BK_DIVIDE: begin
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          state_next = BK_HOLD;
        end
      end
      BK_HOLD: begin
        if (out_free) begin
          load_div   = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase

    trial = {rem, work[SUM_W-1]};
    ge    = (trial >= {1'b0, divisor});
    diff  = trial - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_pass || load_div) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_pass) begin
      average      <= q_head.value[31:0];
      channel      <= q_head.channel;
      last_channel <= q_head.last;
    end else if (load_div) begin
      average      <= neg ? -work[31:0] : work[31:0];
      channel      <= job_ch;
      last_channel <= job_last;
    end

    if (state == BK_IDLE && q_pop && !q_head.pass) begin
      neg      <= q_head.value[SUM_W-1];
      work     <= q_head.value[SUM_W-1] ? -q_head.value : q_head.value;
      rem      <= '0;
      divisor  <= q_head.dec;
      step     <= '0;
      job_ch   <= q_head.channel;
      job_last <= q_head.last;
    end else if (state == BK_DIVIDE) begin
      rem  <= ge ? diff[DEC_W-1:0] : trial[DEC_W-1:0];
      work <= {work[SUM_W-2:0], ge};
      step <= step + STEP_W'(1);
    end
  end

  assign empty = !out_valid;

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == BK_HOLD) |-> (rem < divisor))
    else $error("division remainder not below divisor");

  a_pop_fills: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (out_valid || state == BK_DIVIDE))
    else $error("popped job neither delivered nor dividing");

endmodule

// ===== design/multichannel_boxcar_decimator_core.sv =====
// Top level of the multichannel boxcar average decimator.
//
// Input side is a queue: drive sample with push; a transfer happens on a clock
// edge with push high and full low. Samples are channel-interleaved; the block
// counts the channel position itself and wraps it at channel_count.
// Result side is a queue too: while empty is low, average/channel/last_channel
// show the oldest result; a transfer happens on an edge with pop high.
// Configuration: cfg_we, cfg_index (0 enable, 1 decimation, 2 channel_count)
// and cfg_data write a register; each write to one of these registers clears
// all window sums and the window count. Write only while the block is idle.
// Throughput: the front end takes one sample per cycle as long as the four-
// entry job queue has room. Pass-through results leave at one per cycle while
// the receiver keeps pop high. Each averaged result occupies the bit-serial
// divider through load, 44 quotient bits and hand-off, so the divider sets
// the rate whenever many window ends fall close together; the queue then
// fills and full rises. A pass-through result goes through the job queue and
// the result register, an average also through the divider; stalls delay both.
// Reset (rst, synchronous): enable 0, decimation 1, channel_count 1,
// position and sums zero, queue and result register empty.
// A stalled receiver holds the result register; the divider finishes and
// waits, the queue absorbs up to four jobs, then full stalls the sender.
module multichannel_boxcar_decimator_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic signed [31:0]            sample,
  output logic                          empty,
  input  logic                          pop,
  output logic signed [31:0]            average,
  output logic [3:0]                    channel,
  output logic                          last_channel,
  input  logic                          cfg_we,
  input  mbd_pkg::cfg_index_t           cfg_index,
  input  logic [mbd_pkg::DEC_W-1:0]     cfg_data
);
  import mbd_pkg::*;

  logic job_push;
  job_t job;
  logic q_pop;
  logic q_empty;
  job_t q_head;

  // Accumulate per channel and emit pass-through or divide jobs.
  mbd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .q_full    (full),
    .sample    (sample),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .job_push  (job_push),
    .job       (job)
  );

  // Decouple the one-per-cycle front from the slow divider.
  mbd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .q_push  (job_push),
    .q_din   (job),
    .q_pop   (q_pop),
    .q_full  (full),
    .q_empty (q_empty),
    .q_head  (q_head)
  );

  // Divide with truncation toward zero and hold the result for the receiver.
  mbd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .pop          (pop),
    .empty        (empty),
    .average      (average),
    .channel      (channel),
    .last_channel (last_channel)
  );

endmodule

// ===== tb/sv/multichannel_boxcar_decimator_core_test.sv =====
// Self-checking testbench for the multichannel boxcar average decimator core.
module multichannel_boxcar_decimator_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mbd_pkg::*;

  // Index 3 is not a register; a write to it must change nothing.
  localparam cfg_index_t CFG_UNUSED = 2'd3;

  // Wait after the last result before touching configuration or ending: a
  // sample that completes no window may still sit in the front end.
  localparam int SETTLE_CYCLES = 64;
  localparam int RANDOM_ITEMS  = 800;

  // One result as it leaves the block.
  typedef struct packed {
    logic signed [31:0] avg;
    logic [3:0]         ch;
    logic               last;
  } outcome_t;

  logic clk = 1'b0;
  logic rst;
  logic push;
  logic full;
  logic signed [31:0] sample;
  logic empty;
  logic pop;
  logic signed [31:0] average;
  logic [3:0] channel;
  logic last_channel;
  logic cfg_we;
  cfg_index_t cfg_index;
  logic [DEC_W-1:0] cfg_data;

  multichannel_boxcar_decimator_core dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .sample(sample),
    .empty(empty),
    .pop(pop),
    .average(average),
    .channel(channel),
    .last_channel(last_channel),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #4ns clk = ~clk;

  // Predicted state of the decimator: registers as written, per-channel
  // window sums, channel position and completed sample sets in the window.
  logic             avg_on;
  logic [DEC_W-1:0] dec_reg;
  logic [NCH_W-1:0] nch_reg;
  longint           window_sum [MAX_CHANNELS];
  logic [CH_W-1:0]  ch_pos;
  int unsigned      sets_done;

  outcome_t queued_outputs[$];
  int       error_count;

  // When set, neither side inserts gaps (stretches of full-rate traffic).
  bit steady_flow;
  int pop_hold;

  // Gap length: mostly none, some short, a few long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (steady_flow || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [31:0] pick_sample();
    int r;
    r = $urandom_range(9);
    case (r)
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2, 3, 4: return $signed($urandom_range(200)) - 100;
      default: return $urandom();
    endcase
  endfunction

  task automatic clear_windows();
    foreach (window_sum[i]) window_sum[i] = 0;
    sets_done = 0;
  endtask

  // Advance the predicted state by one accepted sample; queue the result it
  // produces, if any.
  task automatic decimate_sample(input logic signed [31:0] value);
    int unsigned n;
    int unsigned d;
    int unsigned p;
    bit          is_last;
    outcome_t    res;
    n = nch_reg;
    if (n < 1) n = 1;
    if (n > MAX_CHANNELS) n = MAX_CHANNELS;
    d = dec_reg;
    if (d > MAX_DECIMATION) d = MAX_DECIMATION;
    p = ch_pos;
    // A position left over from a larger channel count restarts at zero.
    if (p >= n) p = 0;
    is_last = (p == n - 1);
    res.ch = p[3:0];
    res.last = is_last;
    if (!avg_on || d <= 1) begin
      res.avg = value;
      queued_outputs = {queued_outputs, res};
    end else begin
      window_sum[p] += longint'(value);
      if (sets_done >= d - 1) begin
        // Signed division truncates toward zero, as the block must.
        res.avg = 32'(window_sum[p] / longint'(d));
        queued_outputs = {queued_outputs, res};
        window_sum[p] = 0;
      end
      if (is_last) begin
        sets_done++;
        if (sets_done >= d) sets_done = 0;
      end
    end
    ch_pos = is_last ? 4'd0 : 4'(p + 1);
  endtask

  task automatic note_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("ERROR at %0t: %s", $realtime, msg);
  endtask

  // Send one sample; hold push high afterwards so back-to-back transfers
  // need no extra step.
  task automatic send_sample(input logic signed [31:0] value);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    sample <= value;
    do @(posedge clk); while (full);
    decimate_sample(value);
  endtask

  // Drop push, wait until every predicted result has been taken, then settle.
  task automatic drain_results();
    int waited;
    push <= 1'b0;
    waited = 0;
    while (queued_outputs.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write; only called while the block is drained.
  task automatic write_reg(input cfg_index_t idx, input logic [DEC_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      CFG_ENABLE: begin
        avg_on = value[0];
        clear_windows();
      end
      CFG_DECIMATION: begin
        dec_reg = value;
        clear_windows();
      end
      CFG_CHANNEL_COUNT: begin
        nch_reg = value[NCH_W-1:0];
        clear_windows();
      end
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic en, input logic [DEC_W-1:0] dec,
                           input logic [DEC_W-1:0] nch);
    drain_results();
    write_reg(CFG_ENABLE, {12'd0, en});
    write_reg(CFG_DECIMATION, dec);
    write_reg(CFG_CHANNEL_COUNT, nch);
  endtask

  // Receiver: pop with random stalls of random length.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      pop_hold = 0;
    end else if (pop_hold > 0) begin
      pop <= 1'b0;
      pop_hold--;
    end else begin
      pop <= 1'b1;
      pop_hold = pick_gap();
    end
  end

  // Compare each transfer on the result side with the oldest prediction.
  always @(posedge clk) begin
    outcome_t want;
    if (!rst && pop && !empty) begin
      if (queued_outputs.size() == 0) begin
        note_error($sformatf("unexpected result average=%0d channel=%0d last=%0b",
                             average, channel, last_channel));
      end else begin
        want = queued_outputs.pop_front();
        if (average !== want.avg || channel !== want.ch || last_channel !== want.last)
          note_error($sformatf(
            "expected average=%0d channel=%0d last=%0b, got average=%0d channel=%0d last=%0b",
            want.avg, want.ch, want.last, average, channel, last_channel));
      end
    end
  end

  // Reset values: pass-through on one channel. Bit patterns here toggle every
  // bit of the sample.
  task automatic test_reset_passthrough();
    send_sample(32'sd0);
    send_sample(-32'sd1);
    send_sample(32'sh7FFF_FFFF);
    send_sample(32'sh8000_0000);
    send_sample(32'sh5555_5555);
    send_sample(32'shAAAA_AAAA);
  endtask

  // Pass-through with averaging off, with decimation 1 and with decimation 0;
  // position still wraps at the channel count.
  task automatic test_passthrough_modes();
    configure(1'b0, 13'd5, 13'd4);
    repeat (6) send_sample(pick_sample());
    configure(1'b1, 13'd1, 13'd3);
    repeat (4) send_sample(pick_sample());
    configure(1'b1, 13'd0, 13'd2);
    repeat (3) send_sample(pick_sample());
  endtask

  // Two windows of three sets on two channels; negative sums must truncate
  // toward zero, not round down.
  task automatic test_truncation();
    logic signed [31:0] seq [12] = '{-32'sd1, 32'sd2, -32'sd1, 32'sd2, -32'sd3, 32'sd1,
                                     -32'sd1, 32'sd7, 32'sd0, 32'sd7, 32'sd0, 32'sd7};
    configure(1'b1, 13'd3, 13'd2);
    foreach (seq[i]) send_sample(seq[i]);
  endtask

  // Channel count zero behaves as one; counts above sixteen saturate.
  // Write data with high bits set to check register masking.
  task automatic test_count_limits();
    configure(1'b1, 13'd2, 13'd0);
    repeat (4) send_sample(pick_sample());
    configure(1'b1, 13'd2, 13'd31);
    repeat (32) send_sample(pick_sample());
    configure(1'b0, 13'd2, 13'h1FE3);
    repeat (3) send_sample(pick_sample());
    drain_results();
    write_reg(CFG_ENABLE, 13'd2);
    repeat (3) send_sample(pick_sample());
  endtask

  // Shrink the channel count while the position sits beyond the new count.
  task automatic test_position_shrink();
    configure(1'b0, 13'd1, 13'd8);
    repeat (5) send_sample(pick_sample());
    drain_results();
    write_reg(CFG_CHANNEL_COUNT, 13'd3);
    repeat (4) send_sample(pick_sample());
  endtask

  // A register write clears partial sums; a write to the unused index does not.
  task automatic test_write_clears();
    configure(1'b1, 13'd2, 13'd1);
    send_sample(32'sd1000);
    drain_results();
    write_reg(CFG_DECIMATION, 13'd2);
    send_sample(-32'sd7);
    send_sample(32'sd2);
    send_sample(32'sd100);
    drain_results();
    write_reg(CFG_UNUSED, 13'h1FFF);
    send_sample(-32'sd301);
  endtask

  // Full-scale samples over a long window push the sum far past 32 bits at
  // both ends. An oversized decimation saturates and keeps averaging.
  task automatic test_extreme_windows();
    steady_flow = 1'b1;
    configure(1'b1, 13'd128, 13'd1);
    repeat (128) send_sample(32'sh8000_0000);
    repeat (128) send_sample(32'sh7FFF_FFFF);
    configure(1'b1, 13'h1FFF, 13'd1);
    repeat (8) send_sample(32'sh7FFF_FFFF);
    drain_results();
    steady_flow = 1'b0;
  endtask

  // Random settings per phase, random samples; phases stop mid-window at random.
  task automatic test_random_traffic();
    int items;
    int r;
    int len;
    logic en;
    logic [DEC_W-1:0] dec;
    logic [DEC_W-1:0] nch;
    int unsigned n_eff;
    int unsigned d_eff;
    items = 0;
    while (items < RANDOM_ITEMS) begin
      en = ($urandom_range(7) != 0);
      r = $urandom_range(99);
      nch = (r < 5) ? 13'd0 : (r < 12) ? 13'($urandom_range(17, 31))
                                       : 13'($urandom_range(1, 16));
      r = $urandom_range(99);
      if (r < 10) dec = 13'($urandom_range(1));
      else if (r < 80) dec = 13'($urandom_range(2, 6));
      else if (r < 95) begin
        dec = 13'($urandom_range(7, 24));
        nch = 13'($urandom_range(1, 4));
      end else begin
        dec = 13'($urandom_range(40, 96));
        nch = 13'd1;
      end
      n_eff = (nch[4:0] == 0) ? 1 : (nch[4:0] > MAX_CHANNELS) ? MAX_CHANNELS : nch[4:0];
      d_eff = dec;
      steady_flow = ($urandom_range(4) == 0);
      configure(en, dec, nch);
      len = $urandom_range(30, 150);
      if (en && d_eff > 1 && len < 2 * n_eff * d_eff)
        len = 2 * n_eff * d_eff + $urandom_range(n_eff * d_eff);
      repeat (len) send_sample(pick_sample());
      items += len;
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    rst <= 1'b1;
    push <= 1'b0;
    sample <= '0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_ENABLE;
    cfg_data <= '0;
    avg_on = 1'b0;
    dec_reg = 13'd1;
    nch_reg = 5'd1;
    ch_pos = '0;
    clear_windows();
    error_count = 0;
    steady_flow = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_passthrough();
    test_passthrough_modes();
    test_truncation();
    test_count_limits();
    test_position_shrink();
    test_write_clears();
    test_extreme_windows();
    test_random_traffic();

    drain_results();
    if (queued_outputs.size() != 0)
      note_error($sformatf("%0d predicted results never arrived", queued_outputs.size()));
    if (error_count == 0)
      $display("multichannel_boxcar_decimator_core_test: done, clean");
    else
      $display("multichannel_boxcar_decimator_core_test: done, errors");
    $finish;
  end

  // Hard stop far beyond the slowest legal run.
  initial begin
    #50ms;
    $display("multichannel_boxcar_decimator_core_test: done, errors");
    $finish;
  end

endmodule
